[hdl/qjtg_pkg.sv]
// Shared types, constants and the home pose table for the quintic joint
// trajectory generator. No dependencies.
package qjtg_pkg;

  localparam int NUM_JOINTS_DEF = 7;
  localparam int MAX_JOINTS     = 8;
  localparam int TICK_W         = 17;
  localparam int ANGLE_W        = 16;
  localparam int TIME_W         = 26;
  localparam int TAU_W          = 17;

  localparam logic [TIME_W-1:0] MOVE_TIME_RESET = 26'd8000000;
  localparam logic [TAU_W-1:0]  ONE_Q16         = 17'd65536;

  typedef enum logic [1:0] {
    OP_T2,
    OP_T3,
    OP_S,
    OP_J
  } mul_op_t;

  typedef struct packed {
    logic    accept;
    logic    div_init;
    logic    div_step;
    logic    mul_en;
    logic    wb_en;
    mul_op_t op;
    logic    joint_clr;
    logic    joint_inc;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic joint_last;
  } dp_stat_t;

  // home pose, Q4.12 radians
  function automatic logic signed [ANGLE_W-1:0] home_angle(logic [2:0] idx);
    logic signed [ANGLE_W-1:0] a;
    case (idx)
      3'd1:    a = -16'sd3215;
      3'd3:    a = -16'sd9650;
      3'd5:    a = 16'sd6435;
      3'd6:    a = 16'sd3215;
      default: a = 16'sd0;
    endcase
    return a;
  endfunction

endpackage

[hdl/qjtg_datapath.sv]
// Datapath: move time register, elapsed time, start pose, radix-2 divider
// for tau, one shared multiplier and the output register. Uses qjtg_pkg.
module qjtg_datapath #(
  parameter int NUM_JOINTS = qjtg_pkg::NUM_JOINTS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  input  logic [qjtg_pkg::TIME_W-1:0]               cfg_data,
  input  logic [qjtg_pkg::TICK_W-1:0]               in_tick,
  input  logic                                      in_stop,
  input  logic [NUM_JOINTS*qjtg_pkg::ANGLE_W-1:0]   in_joints,
  input  qjtg_pkg::dp_cmd_t                         cmd,
  output qjtg_pkg::dp_stat_t                        stat,
  output logic [NUM_JOINTS*qjtg_pkg::ANGLE_W-1:0]   out_joints,
  output logic                                      out_fin
);

  localparam int AW = qjtg_pkg::ANGLE_W;
  localparam int TW = qjtg_pkg::TIME_W;
  localparam int QW = qjtg_pkg::TAU_W;
  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  logic [TW-1:0]   move_time_r;
  logic [TW-1:0]   elapsed_r;
  logic            latched_r;
  logic [TW-1:0]   e_r;
  logic            fin_r;
  logic [TW-1:0]   rem_r;
  logic [QW-1:0]   tau_r;
  logic [QW-1:0]   t2_r;
  logic [QW-1:0]   t3_r;
  logic [QW-1:0]   s_r;
  logic signed [38:0] mul_r;
  logic [JW-1:0]   j_r;
  logic signed [AW-1:0] start_r [NUM_JOINTS];
  logic signed [AW-1:0] cmdj_r  [NUM_JOINTS];
  logic signed [AW-1:0] outj_r  [NUM_JOINTS];
  logic            out_fin_r;

  logic [TW-1:0]   mt;
  logic [TW:0]     e_sum;
  logic [TW-1:0]   e_sat;
  logic            e_done;
  logic [TW:0]     rem2;
  logic            rem_ge;
  logic [21:0]     p_add;
  logic [21:0]     p_sub;
  logic [19:0]     p_val;
  logic signed [AW-1:0] st;
  logic signed [AW-1:0] home;
  logic signed [AW:0]   diff;
  logic signed [20:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [38:0]   rnd_full;
  logic signed [22:0]   rnd;
  logic signed [22:0]   c_full;
  logic signed [AW-1:0] c_sat;

  assign mt     = (move_time_r == '0) ? TW'(1) : move_time_r;
  assign e_sum  = {1'b0, elapsed_r} + {{(TW+1-qjtg_pkg::TICK_W){1'b0}}, in_tick};
  assign e_sat  = (e_sum > {1'b0, mt}) ? mt : e_sum[TW-1:0];
  assign e_done = (e_sum >= {1'b0, mt});

  assign rem2   = {rem_r, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, mt});

  // 10 - 15t + 6t^2 in Q16
  assign p_add = 22'd655360 + ({5'b0, t2_r} << 2) + ({5'b0, t2_r} << 1);
  assign p_sub = ({5'b0, tau_r} << 4) - {5'b0, tau_r};
  assign p_val = (p_add >= p_sub) ? 20'(p_add - p_sub) : 20'd0;

  assign st   = start_r[j_r];
  assign home = qjtg_pkg::home_angle(3'(j_r));
  assign diff = {home[AW-1], home} - {st[AW-1], st};

  always_comb begin
    case (cmd.op)
      qjtg_pkg::OP_T2: begin
        mul_a = $signed({4'b0, tau_r});
        mul_b = $signed({1'b0, tau_r});
      end
      qjtg_pkg::OP_T3: begin
        mul_a = $signed({4'b0, t2_r});
        mul_b = $signed({1'b0, tau_r});
      end
      qjtg_pkg::OP_S: begin
        mul_a = $signed({1'b0, p_val});
        mul_b = $signed({1'b0, t3_r});
      end
      default: begin
        mul_a = $signed({4'b0, s_r});
        mul_b = {diff[AW], diff};
      end
    endcase
  end

  assign rnd_full = mul_r + 39'sd32768;
  assign rnd      = rnd_full[38:16];
  assign c_full   = {{(23-AW){st[AW-1]}}, st} + rnd;
  assign c_sat    = (c_full > 23'sd32767)  ? 16'sh7fff :
                    (c_full < -23'sd32768) ? 16'sh8000 : c_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_time_r <= qjtg_pkg::MOVE_TIME_RESET;
      elapsed_r   <= '0;
      latched_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        move_time_r <= cfg_data;
      end
      if (cmd.accept) begin
        elapsed_r <= (in_stop || e_done) ? '0 : e_sat;
        latched_r <= !(in_stop || e_done);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      e_r   <= e_sat;
      fin_r <= in_stop || e_done;
      if (!latched_r) begin
        for (int i = 0; i < NUM_JOINTS; i++) begin
          start_r[i] <= in_joints[i*AW +: AW];
        end
      end
    end
    if (cmd.div_init) begin
      tau_r <= {{(QW-1){1'b0}}, (e_r >= mt)};
      rem_r <= (e_r >= mt) ? e_r - mt : e_r;
    end
    if (cmd.div_step) begin
      tau_r <= {tau_r[QW-2:0], rem_ge};
      rem_r <= rem_ge ? TW'(rem2 - {1'b0, mt}) : rem2[TW-1:0];
    end
    if (cmd.mul_en) begin
      mul_r <= $signed({{18{mul_a[20]}}, mul_a}) * $signed({{21{mul_b[17]}}, mul_b});
    end
    if (cmd.wb_en) begin
      case (cmd.op)
        qjtg_pkg::OP_T2: t2_r <= rnd[QW-1:0];
        qjtg_pkg::OP_T3: t3_r <= rnd[QW-1:0];
        qjtg_pkg::OP_S:  s_r  <= (rnd > 23'sd65536) ? qjtg_pkg::ONE_Q16 : rnd[QW-1:0];
        default:         cmdj_r[j_r] <= c_sat;
      endcase
    end
    if (cmd.joint_clr) begin
      j_r <= '0;
    end else if (cmd.joint_inc) begin
      j_r <= j_r + JW'(1);
    end
    if (cmd.out_load) begin
      outj_r    <= cmdj_r;
      out_fin_r <= fin_r;
    end
  end

  assign stat.joint_last = (j_r == JW'(NUM_JOINTS - 1));

  always_comb begin
    for (int i = 0; i < NUM_JOINTS; i++) begin
      out_joints[i*AW +: AW] = outj_r[i];
    end
  end
  assign out_fin = out_fin_r;

  a_elapsed_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (e_r <= mt))
    else $error("working elapsed time exceeds move time");

  a_tau_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_en && cmd.op == qjtg_pkg::OP_T2) |-> (tau_r <= qjtg_pkg::ONE_Q16))
    else $error("tau above one after division");

  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb_en && cmd.op == qjtg_pkg::OP_S) |=> (s_r <= qjtg_pkg::ONE_Q16))
    else $error("blend above one");

endmodule

[hdl/qjtg_ctrl.sv]
// Controller: sequences acceptance, division steps, multiply and write-back
// phases and the output register. Uses qjtg_pkg.
module qjtg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output qjtg_pkg::dp_cmd_t   cmd,
  input  qjtg_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DINIT,
    S_DIV,
    S_MUL,
    S_WB,
    S_DONE
  } state_t;

  state_t            state_r;
  qjtg_pkg::mul_op_t op_r;
  logic [3:0]        cnt_r;
  logic              out_tvalid_r;

  always_comb begin
    cmd       = '0;
    cmd.op    = op_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_DINIT: cmd.div_init = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_MUL:   cmd.mul_en   = 1'b1;
      S_WB: begin
        cmd.wb_en     = 1'b1;
        cmd.joint_clr = (op_r == qjtg_pkg::OP_S);
        cmd.joint_inc = (op_r == qjtg_pkg::OP_J) && !stat.joint_last;
      end
      S_DONE:  cmd.out_load = !out_tvalid_r || out_tready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= qjtg_pkg::OP_T2;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_DINIT;
          end
        end
        S_DINIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            op_r    <= qjtg_pkg::OP_T2;
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_WB;
        S_WB: begin
          case (op_r)
            qjtg_pkg::OP_T2: begin
              op_r    <= qjtg_pkg::OP_T3;
              state_r <= S_MUL;
            end
            qjtg_pkg::OP_T3: begin
              op_r    <= qjtg_pkg::OP_S;
              state_r <= S_MUL;
            end
            qjtg_pkg::OP_S: begin
              op_r    <= qjtg_pkg::OP_J;
              state_r <= S_MUL;
            end
            default: state_r <= stat.joint_last ? S_DONE : S_MUL;
          endcase
        end
        S_DONE: begin
          if (cmd.out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DINIT))
    else $error("accepted request did not start division");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == 4'd15) |=> (state_r == S_MUL && op_r == qjtg_pkg::OP_T2))
    else $error("division did not end after sixteen steps");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_tvalid && state_r == S_IDLE))
    else $error("output load did not raise valid");

endmodule

[hdl/quintic_joint_trajectory_generator.sv]
// Top level of the quintic joint trajectory generator: controller plus
// datapath. Uses qjtg_pkg, qjtg_ctrl and qjtg_datapath.
//
// One request per control tick yields one result carrying every joint's
// command and the finished flag (on out_tlast). A sixteen-step radix-2
// divider forms tau, then a single shared multiplier runs t^2, t^3, the
// blend and one product per joint, each followed by a rounding write-back
// step. A result waiting in the output register does not block acceptance
// of the next request, but that request's result waits in the done state
// until out_tready takes the old one. move_time_us must be written on the
// cfg channel only between ticks; the block itself does not enforce it. A
// value of zero acts as one.
module quintic_joint_trajectory_generator #(
  parameter int NUM_JOINTS = qjtg_pkg::NUM_JOINTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [qjtg_pkg::TIME_W-1:0] cfg_data,  // move_time_us
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // tick_period_us, current_joint_0 .. current_joint_N-1, zero pad
  input  logic [((qjtg_pkg::TICK_W + NUM_JOINTS*qjtg_pkg::ANGLE_W + 7)/8)*8-1:0] in_tdata,
  input  logic                    in_tlast,   // stop_request
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // command_joint_0 .. command_joint_N-1
  output logic [NUM_JOINTS*qjtg_pkg::ANGLE_W-1:0] out_tdata,
  output logic                    out_tlast   // motion_finished
);

  localparam int JB = NUM_JOINTS * qjtg_pkg::ANGLE_W;

  qjtg_pkg::dp_cmd_t  cmd;
  qjtg_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  qjtg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  qjtg_datapath #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tick    (in_tdata[qjtg_pkg::TICK_W-1:0]),
    .in_stop    (in_tlast),
    .in_joints  (in_tdata[qjtg_pkg::TICK_W +: JB]),
    .cmd        (cmd),
    .stat       (stat),
    .out_joints (out_tdata),
    .out_fin    (out_tlast)
  );

endmodule
